// File: rtl/core/narrow_phase_collision_test_top_assert.svh
// Assertion macros used by the collision test RTL
`ifndef NARROW_PHASE_COLLISION_TEST_TOP_ASSERT_SVH
`define NARROW_PHASE_COLLISION_TEST_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define NPCT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define NPCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/npct_pkg.sv
// Shared types and constants of the narrow-phase collision test
package npct_pkg;

    localparam int SIZE_BITS = 20;
    localparam int NORM_BITS = 16;
    localparam int V_BITS    = 22;
    localparam int R_BITS    = 21;
    localparam int SQ_BITS   = 44;
    localparam int ROOT_BITS = 22;
    localparam int Q_BITS    = 15;
    localparam int NUM_BITS  = 36;

    localparam logic signed [NORM_BITS-1:0] NORM_ONE = 16'sd16384;

    localparam logic [1:0] KIND_CC = 2'd0;
    localparam logic [1:0] KIND_BB = 2'd1;
    localparam logic [1:0] KIND_CB = 2'd2;
    localparam logic [1:0] KIND_BC = 2'd3;

    typedef enum logic [1:0] {
        MODE_ROUND,
        MODE_BOX,
        MODE_CBOX,
        MODE_INSIDE
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic               hit;
        logic               zero;
        logic               neg;
        logic               xaxis;
        logic               pos;
        logic [R_BITS-1:0]  r2;
        logic [V_BITS-1:0]  vx;
        logic [V_BITS-1:0]  vy;
    } t_side;

endpackage

// File: rtl/core/npct_prep.sv
// Geometry front end: offsets, early rejects, box result, squared distance
module npct_prep #(
    parameter int COORD_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [1:0]                      i_kind,
    input  logic signed [COORD_BITS-1:0]    i_a_x,
    input  logic signed [COORD_BITS-1:0]    i_a_y,
    input  logic [npct_pkg::SIZE_BITS-1:0]  i_a_w,
    input  logic [npct_pkg::SIZE_BITS-1:0]  i_a_h,
    input  logic signed [COORD_BITS-1:0]    i_b_x,
    input  logic signed [COORD_BITS-1:0]    i_b_y,
    input  logic [npct_pkg::SIZE_BITS-1:0]  i_b_w,
    input  logic [npct_pkg::SIZE_BITS-1:0]  i_b_h,
    output logic                            o_valid,
    output logic [npct_pkg::SQ_BITS-1:0]    o_dsq,
    output npct_pkg::t_side                 o_side
);
    import npct_pkg::*;

    localparam int EW = (COORD_BITS > V_BITS) ? COORD_BITS : V_BITS;
    localparam int DW = EW + 4;

    // stage A: per-kind offsets in half-units
    logic signed [DW-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    logic signed [DW-1:0] cx, cy, qx, qy, qw, qh;
    logic signed [DW-1:0] cc_dx, cc_dy, bb_dx, bb_dy;
    logic signed [DW-1:0] lo_x, lo_y, hi_x, hi_y, cb_dx, cb_dy, ex, ey;
    logic [R_BITS-1:0]    cdiam;
    logic signed [DW-1:0] n_a_dx, n_a_dy;
    logic [R_BITS-1:0]    n_a_r2, n_a_rh;
    t_mode                n_a_mode;
    logic                 n_a_neg;

    logic                 r_a_valid;
    t_mode                r_a_mode;
    logic                 r_a_neg;
    logic signed [DW-1:0] r_a_dx, r_a_dy;
    logic [V_BITS-1:0]    r_a_ex, r_a_ey;
    logic [R_BITS-1:0]    r_a_r2, r_a_rh;

    assign ax = DW'(i_a_x);
    assign ay = DW'(i_a_y);
    assign bx = DW'(i_b_x);
    assign by = DW'(i_b_y);
    assign aw = DW'(i_a_w);
    assign ah = DW'(i_a_h);
    assign bw = DW'(i_b_w);
    assign bh = DW'(i_b_h);

    always_comb begin
        if (i_kind == KIND_BC) begin
            cx = bx; cy = by; cdiam = R_BITS'(i_b_w);
            qx = ax; qy = ay; qw = aw; qh = ah;
        end else begin
            cx = ax; cy = ay; cdiam = R_BITS'(i_a_w);
            qx = bx; qy = by; qw = bw; qh = bh;
        end
        cc_dx = (bx + bx) - (ax + ax);
        cc_dy = (by + by) - (ay + ay);
        bb_dx = (bx + bx + bw) - (ax + ax + aw);
        bb_dy = (by + by + bh) - (ay + ay + ah);
        lo_x  = (qx + qx) - (cx + cx);
        lo_y  = (qy + qy) - (cy + cy);
        hi_x  = (qx + qx + qw + qw) - (cx + cx);
        hi_y  = (qy + qy + qh + qh) - (cy + cy);
        cb_dx = (lo_x > 0) ? lo_x : ((hi_x < 0) ? hi_x : '0);
        cb_dy = (lo_y > 0) ? lo_y : ((hi_y < 0) ? hi_y : '0);
        ex    = (cx + cx) - (qx + qx + qw);
        ey    = (cy + cy) - (qy + qy + qh);

        case (i_kind)
            KIND_CC: begin
                n_a_mode = MODE_ROUND;
                n_a_neg  = 1'b0;
                n_a_dx   = cc_dx;
                n_a_dy   = cc_dy;
                n_a_r2   = R_BITS'(i_a_w) + R_BITS'(i_b_w);
                n_a_rh   = '0;
            end
            KIND_BB: begin
                n_a_mode = MODE_BOX;
                n_a_neg  = 1'b0;
                n_a_dx   = bb_dx;
                n_a_dy   = bb_dy;
                n_a_r2   = R_BITS'(i_a_w) + R_BITS'(i_b_w);
                n_a_rh   = R_BITS'(i_a_h) + R_BITS'(i_b_h);
            end
            default: begin
                n_a_mode = MODE_CBOX;
                n_a_neg  = (i_kind == KIND_BC);
                n_a_dx   = cb_dx;
                n_a_dy   = cb_dy;
                n_a_r2   = cdiam;
                n_a_rh   = '0;
            end
        endcase
    end

    // stage B: reach tests, inside check, box overlaps
    logic signed [DW-1:0] r2e, rhe, sum_xp, sum_xm, sum_yp, sum_ym, ox, oy;
    logic                 out_x, out_y, at_zero;
    t_mode                n_b_mode;
    logic                 n_b_hit;

    logic                     r_b_valid;
    t_mode                    r_b_mode;
    logic                     r_b_neg, r_b_hit, r_b_xpos, r_b_ypos;
    logic signed [V_BITS-1:0] r_b_vx, r_b_vy;
    logic [R_BITS-1:0]        r_b_r2;
    logic signed [DW-1:0]     r_b_ox, r_b_oy;

    always_comb begin
        r2e    = DW'(r_a_r2);
        rhe    = DW'(r_a_rh);
        sum_xp = r_a_dx + r2e;
        sum_xm = r_a_dx - r2e;
        sum_yp = r_a_dy + r2e;
        sum_ym = r_a_dy - r2e;
        out_x  = r_a_dx[DW-1] ? (sum_xp <= 0) : (sum_xm >= 0);
        out_y  = r_a_dy[DW-1] ? (sum_yp <= 0) : (sum_ym >= 0);
        at_zero = (r_a_dx == '0) && (r_a_dy == '0);
        ox = r_a_dx[DW-1] ? (r2e + r_a_dx) : (r2e - r_a_dx);
        oy = r_a_dy[DW-1] ? (rhe + r_a_dy) : (rhe - r_a_dy);
        n_b_mode = r_a_mode;
        if (r_a_mode == MODE_CBOX) begin
            n_b_mode = at_zero ? MODE_INSIDE : MODE_ROUND;
        end
        n_b_hit = (n_b_mode == MODE_INSIDE) ? (r_a_r2 != '0) : !(out_x || out_y);
    end

    // stage C: box decision, squares
    logic signed [2*V_BITS-1:0] sq_x, sq_y;
    logic [2*R_BITS-1:0]        rsq;
    logic                       box_hit, box_x;
    t_side                      n_c_side;

    logic                  r_c_valid;
    t_side                 r_c_side;
    logic [SQ_BITS-1:0]    r_c_sqx, r_c_sqy;
    logic [2*R_BITS-1:0]   r_c_rsq;

    assign sq_x = r_b_vx * r_b_vx;
    assign sq_y = r_b_vy * r_b_vy;
    assign rsq  = r_b_r2 * r_b_r2;

    always_comb begin
        box_hit = (r_b_ox > 0) && (r_b_oy > 0);
        box_x   = (r_b_ox < r_b_oy);
        n_c_side.mode  = r_b_mode;
        n_c_side.zero  = 1'b0;
        n_c_side.neg   = r_b_neg;
        n_c_side.xaxis = box_x;
        n_c_side.pos   = box_x ? r_b_xpos : r_b_ypos;
        n_c_side.vx    = r_b_vx;
        n_c_side.vy    = r_b_vy;
        if (r_b_mode == MODE_BOX) begin
            n_c_side.hit = box_hit;
            n_c_side.r2  = box_x ? r_b_ox[R_BITS-1:0] : r_b_oy[R_BITS-1:0];
        end else begin
            n_c_side.hit = r_b_hit;
            n_c_side.r2  = r_b_r2;
        end
    end

    // stage D: distance squared; stage E: radius compare
    logic                  r_d_valid;
    t_side                 r_d_side;
    logic [SQ_BITS-1:0]    r_d_dsq;
    logic [2*R_BITS-1:0]   r_d_rsq;
    t_side                 n_e_side;

    logic                  r_e_valid;
    t_side                 r_e_side;
    logic [SQ_BITS-1:0]    r_e_dsq;

    always_comb begin
        n_e_side      = r_d_side;
        n_e_side.hit  = r_d_side.hit &&
                        ((r_d_side.mode != MODE_ROUND) || (r_d_dsq < SQ_BITS'(r_d_rsq)));
        n_e_side.zero = (r_d_dsq == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mode <= n_a_mode;
        r_a_neg  <= n_a_neg;
        r_a_dx   <= n_a_dx;
        r_a_dy   <= n_a_dy;
        r_a_ex   <= ex[V_BITS-1:0];
        r_a_ey   <= ey[V_BITS-1:0];
        r_a_r2   <= n_a_r2;
        r_a_rh   <= n_a_rh;

        r_b_mode <= n_b_mode;
        r_b_neg  <= r_a_neg;
        r_b_hit  <= n_b_hit;
        r_b_vx   <= (n_b_mode == MODE_INSIDE) ? r_a_ex : r_a_dx[V_BITS-1:0];
        r_b_vy   <= (n_b_mode == MODE_INSIDE) ? r_a_ey : r_a_dy[V_BITS-1:0];
        r_b_r2   <= r_a_r2;
        r_b_ox   <= ox;
        r_b_oy   <= oy;
        r_b_xpos <= !r_a_dx[DW-1] && (r_a_dx != '0);
        r_b_ypos <= !r_a_dy[DW-1] && (r_a_dy != '0);

        r_c_side <= n_c_side;
        r_c_sqx  <= SQ_BITS'(sq_x);
        r_c_sqy  <= SQ_BITS'(sq_y);
        r_c_rsq  <= rsq;

        r_d_side <= r_c_side;
        r_d_dsq  <= r_c_sqx + r_c_sqy;
        r_d_rsq  <= r_c_rsq;

        r_e_side <= n_e_side;
        r_e_dsq  <= r_d_dsq;
    end

    assign o_valid = r_e_valid;
    assign o_dsq   = r_e_dsq;
    assign o_side  = r_e_side;

endmodule

// File: rtl/core/npct_sqrt.sv
// Pipelined integer square root, one result bit per stage
module npct_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [npct_pkg::SQ_BITS-1:0]    i_dsq,
    input  npct_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic [npct_pkg::ROOT_BITS-1:0]  o_root,
    output npct_pkg::t_side                 o_side
);
    import npct_pkg::*;

    localparam int STAGES = ROOT_BITS;

    typedef struct packed {
        logic [SQ_BITS-1:0] rem;
        logic [SQ_BITS-1:0] res;
    } t_sq;

    function automatic t_sq sq_step(input logic [SQ_BITS-1:0] rem,
                                    input logic [SQ_BITS-1:0] res,
                                    input logic [SQ_BITS-1:0] bitv);
        logic [SQ_BITS-1:0] trial;
        t_sq                nxt;
        trial = res + bitv;
        if (rem >= trial) begin
            nxt.rem = rem - trial;
            nxt.res = (res >> 1) + bitv;
        end else begin
            nxt.rem = rem;
            nxt.res = res >> 1;
        end
        return nxt;
    endfunction

    logic [STAGES-1:0]  r_valid;
    logic [SQ_BITS-1:0] r_rem [STAGES];
    logic [SQ_BITS-1:0] r_res [STAGES];
    t_side              r_side [STAGES];
    t_sq                n_st [STAGES];

    always_comb begin
        n_st[0] = sq_step(i_dsq, '0, SQ_BITS'(1) << (2 * (STAGES - 1)));
        for (int i = 1; i < STAGES; i++) begin
            n_st[i] = sq_step(r_rem[i-1], r_res[i-1],
                              SQ_BITS'(1) << (2 * (STAGES - 1 - i)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int i = 0; i < STAGES; i++) begin
            r_rem[i] <= n_st[i].rem;
            r_res[i] <= n_st[i].res;
        end
        for (int i = 1; i < STAGES; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_root  = r_res[STAGES-1][ROOT_BITS-1:0];
    assign o_side  = r_side[STAGES-1];

endmodule

// File: rtl/core/npct_div.sv
// Pipelined Q1.14 normal divide, two lanes sharing one divisor
module npct_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [npct_pkg::ROOT_BITS-1:0]  i_root,
    input  npct_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic [npct_pkg::Q_BITS-1:0]     o_qx,
    output logic [npct_pkg::Q_BITS-1:0]     o_qy,
    output logic [npct_pkg::ROOT_BITS-1:0]  o_root,
    output npct_pkg::t_side                 o_side
);
    import npct_pkg::*;

    localparam int REM_BITS = ROOT_BITS + 1;

    typedef struct packed {
        logic [REM_BITS-1:0] rem;
        logic                q;
    } t_dv;

    function automatic t_dv dv_step(input logic [REM_BITS-1:0]  rem,
                                    input logic                 nb,
                                    input logic [ROOT_BITS-1:0] den);
        logic [REM_BITS-1:0] t;
        t_dv                 nxt;
        t = {rem[REM_BITS-2:0], nb};
        if (t >= {1'b0, den}) begin
            nxt.rem = t - {1'b0, den};
            nxt.q   = 1'b1;
        end else begin
            nxt.rem = t;
            nxt.q   = 1'b0;
        end
        return nxt;
    endfunction

    // numerator: |v| * 2^14 plus half the divisor, for round-half-away
    logic [V_BITS-1:0]    mag_x, mag_y;
    logic [NUM_BITS-1:0]  n_p_numx, n_p_numy;

    logic                 r_p_valid;
    logic [NUM_BITS-1:0]  r_p_numx, r_p_numy;
    logic [ROOT_BITS-1:0] r_p_den, r_p_root;
    t_side                r_p_side;

    always_comb begin
        mag_x    = i_side.vx[V_BITS-1] ? (V_BITS'(0) - i_side.vx) : i_side.vx;
        mag_y    = i_side.vy[V_BITS-1] ? (V_BITS'(0) - i_side.vy) : i_side.vy;
        n_p_numx = {mag_x, 14'b0} + NUM_BITS'(i_root >> 1);
        n_p_numy = {mag_y, 14'b0} + NUM_BITS'(i_root >> 1);
    end

    logic [Q_BITS-1:0]    r_valid;
    logic [REM_BITS-1:0]  r_remx [Q_BITS];
    logic [REM_BITS-1:0]  r_remy [Q_BITS];
    logic [Q_BITS-1:0]    r_qx [Q_BITS];
    logic [Q_BITS-1:0]    r_qy [Q_BITS];
    logic [NUM_BITS-1:0]  r_numx [Q_BITS];
    logic [NUM_BITS-1:0]  r_numy [Q_BITS];
    logic [ROOT_BITS-1:0] r_den [Q_BITS];
    logic [ROOT_BITS-1:0] r_root [Q_BITS];
    t_side                r_side [Q_BITS];
    t_dv                  n_dx [Q_BITS];
    t_dv                  n_dy [Q_BITS];

    always_comb begin
        n_dx[0] = dv_step(REM_BITS'(r_p_numx[NUM_BITS-1:Q_BITS]),
                          r_p_numx[Q_BITS-1], r_p_den);
        n_dy[0] = dv_step(REM_BITS'(r_p_numy[NUM_BITS-1:Q_BITS]),
                          r_p_numy[Q_BITS-1], r_p_den);
        for (int j = 1; j < Q_BITS; j++) begin
            n_dx[j] = dv_step(r_remx[j-1], r_numx[j-1][Q_BITS-1-j], r_den[j-1]);
            n_dy[j] = dv_step(r_remy[j-1], r_numy[j-1][Q_BITS-1-j], r_den[j-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_valid   <= '0;
        end else begin
            r_p_valid <= i_valid;
            r_valid   <= {r_valid[Q_BITS-2:0], r_p_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_numx <= n_p_numx;
        r_p_numy <= n_p_numy;
        r_p_den  <= (i_root == '0) ? ROOT_BITS'(1) : i_root;
        r_p_root <= i_root;
        r_p_side <= i_side;

        r_remx[0] <= n_dx[0].rem;
        r_remy[0] <= n_dy[0].rem;
        r_qx[0]   <= {n_dx[0].q, {(Q_BITS-1){1'b0}}};
        r_qy[0]   <= {n_dy[0].q, {(Q_BITS-1){1'b0}}};
        r_numx[0] <= r_p_numx;
        r_numy[0] <= r_p_numy;
        r_den[0]  <= r_p_den;
        r_root[0] <= r_p_root;
        r_side[0] <= r_p_side;
        for (int j = 1; j < Q_BITS; j++) begin
            r_remx[j] <= n_dx[j].rem;
            r_remy[j] <= n_dy[j].rem;
            r_qx[j]   <= r_qx[j-1] | (Q_BITS'(n_dx[j].q) << (Q_BITS - 1 - j));
            r_qy[j]   <= r_qy[j-1] | (Q_BITS'(n_dy[j].q) << (Q_BITS - 1 - j));
            r_numx[j] <= r_numx[j-1];
            r_numy[j] <= r_numy[j-1];
            r_den[j]  <= r_den[j-1];
            r_root[j] <= r_root[j-1];
            r_side[j] <= r_side[j-1];
        end
    end

    assign o_valid = r_valid[Q_BITS-1];
    assign o_qx    = r_qx[Q_BITS-1];
    assign o_qy    = r_qy[Q_BITS-1];
    assign o_root  = r_root[Q_BITS-1];
    assign o_side  = r_side[Q_BITS-1];

endmodule

// File: rtl/core/narrow_phase_collision_test_top.sv
// Top level of the narrow-phase collision test pipeline
//
// Takes one body pair per clock and returns one contact word per pair, in
// order (a pair is taken when start is high while busy is low). busy never
// rises: the pipeline accepts a new pair every cycle and the receiver cannot
// stall it, so o_strobe marks each result for exactly one cycle. A pair runs
// through the 5-stage geometry front end, the 22-stage integer square root
// (one root bit per stage), the 16-stage Q1.14 divider (operand setup plus
// one quotient bit per stage) and the output register.
// Kinds: circle-circle, box-box, circle A vs box B, box A vs circle B (the
// last is run as circle vs box with the normal flipped). Lengths are in
// 1/16 px, handled internally in half-units so box centres stay exact.
// A miss, or a depth that floors to zero, reads as all-zero fields.
module narrow_phase_collision_test_top #(
    parameter int COORD_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             i_kind,
    input  logic signed [COORD_BITS-1:0]           i_a_x,
    input  logic signed [COORD_BITS-1:0]           i_a_y,
    input  logic [npct_pkg::SIZE_BITS-1:0]         i_a_w,
    input  logic [npct_pkg::SIZE_BITS-1:0]         i_a_h,
    input  logic signed [COORD_BITS-1:0]           i_b_x,
    input  logic signed [COORD_BITS-1:0]           i_b_y,
    input  logic [npct_pkg::SIZE_BITS-1:0]         i_b_w,
    input  logic [npct_pkg::SIZE_BITS-1:0]         i_b_h,
    output logic                                   o_strobe,
    output logic                                   o_collided,
    output logic [npct_pkg::SIZE_BITS-1:0]         o_overlap,
    output logic signed [npct_pkg::NORM_BITS-1:0]  o_normal_x,
    output logic signed [npct_pkg::NORM_BITS-1:0]  o_normal_y
);
    import npct_pkg::*;

    // no back-pressure anywhere in the pipe
    assign busy = 1'b0;

    logic               p_valid;
    logic [SQ_BITS-1:0] p_dsq;
    t_side              p_side;

    logic                 s_valid;
    logic [ROOT_BITS-1:0] s_root;
    t_side                s_side;

    logic                 d_valid;
    logic [Q_BITS-1:0]    d_qx, d_qy;
    logic [ROOT_BITS-1:0] d_root;
    t_side                d_side;

    npct_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_kind  (i_kind),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_a_w   (i_a_w),
        .i_a_h   (i_a_h),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .i_b_w   (i_b_w),
        .i_b_h   (i_b_h),
        .o_valid (p_valid),
        .o_dsq   (p_dsq),
        .o_side  (p_side)
    );

    npct_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p_valid),
        .i_dsq   (p_dsq),
        .i_side  (p_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    npct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .i_root  (s_root),
        .i_side  (s_side),
        .o_valid (d_valid),
        .o_qx    (d_qx),
        .o_qy    (d_qy),
        .o_root  (d_root),
        .o_side  (d_side)
    );

    // output formatting: pick depth and normal by contact mode
    logic signed [NORM_BITS-1:0] qxs, qys, nx, ny;
    logic [R_BITS-1:0]           depth2;
    logic [SIZE_BITS-1:0]        depth;
    logic                        n_collided;

    always_comb begin
        qxs = d_side.vx[V_BITS-1] ? -$signed({1'b0, d_qx}) : $signed({1'b0, d_qx});
        qys = d_side.vy[V_BITS-1] ? -$signed({1'b0, d_qy}) : $signed({1'b0, d_qy});
        nx  = '0;
        ny  = '0;
        case (d_side.mode)
            MODE_BOX: begin
                depth2 = d_side.r2;
                if (d_side.xaxis) begin
                    nx = d_side.pos ? NORM_ONE : -NORM_ONE;
                end else begin
                    ny = d_side.pos ? NORM_ONE : -NORM_ONE;
                end
            end
            MODE_INSIDE: begin
                // centre inside the box: depth is the full radius
                depth2 = d_side.r2;
                nx     = d_side.zero ? NORM_ONE : qxs;
                ny     = d_side.zero ? '0 : qys;
            end
            MODE_ROUND: begin
                // coincident points take the fixed +x normal
                depth2 = d_side.zero ? d_side.r2 : (d_side.r2 - d_root[R_BITS-1:0]);
                nx     = d_side.zero ? NORM_ONE : qxs;
                ny     = d_side.zero ? '0 : qys;
            end
            default: begin
                depth2 = '0;
            end
        endcase
        if (d_side.neg) begin
            nx = -nx;
            ny = -ny;
        end
        depth      = depth2[R_BITS-1:1];
        n_collided = d_side.hit && (depth != '0);
    end

    logic                        r_strobe, r_collided;
    logic [SIZE_BITS-1:0]        r_overlap;
    logic signed [NORM_BITS-1:0] r_normal_x, r_normal_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_collided <= n_collided;
        r_overlap  <= n_collided ? depth : '0;
        r_normal_x <= n_collided ? nx : '0;
        r_normal_y <= n_collided ? ny : '0;
    end

    assign o_strobe   = r_strobe;
    assign o_collided = r_strobe && r_collided;
    assign o_overlap  = r_overlap;
    assign o_normal_x = r_normal_x;
    assign o_normal_y = r_normal_y;

`include "narrow_phase_collision_test_top_assert.svh"

    `NPCT_ASSERT_IMPLY(a_miss_clear, o_strobe && !o_collided,
        o_overlap == '0 && o_normal_x == '0 && o_normal_y == '0, "miss word not cleared")
    `NPCT_ASSERT_IMPLY(a_hit_depth, o_collided, o_strobe && o_overlap != '0,
        "hit word without depth")
    `NPCT_ASSERT_IMPLY(a_norm_range, o_collided,
        o_normal_x <= NORM_ONE && o_normal_x >= -NORM_ONE &&
        o_normal_y <= NORM_ONE && o_normal_y >= -NORM_ONE, "normal out of range")
    `NPCT_ASSERT_NEXT(a_strobe_follows, d_valid, o_strobe, "result word dropped")

endmodule
